// ===== sv/bdr_pkg.sv =====
package bdr_pkg;

  // Fixed widths of the payload fields.
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 7;

  // Default depth of the buffer in bits.
  localparam int BUFFER_WIDTH_DEFAULT = 64;

  // Operation codes carried on func.
  typedef enum logic [2:0] {
    FUNC_LOAD      = 3'd0,
    FUNC_PUSH_LOW  = 3'd1,
    FUNC_POP_LOW   = 3'd2,
    FUNC_PUSH_HIGH = 3'd3,
    FUNC_POP_HIGH  = 3'd4
  } bdr_func_t;

  // One result as it leaves the datapath.
  typedef struct packed {
    logic [DATA_W-1:0]  out_bits;
    logic [COUNT_W-1:0] out_count;
    logic [COUNT_W-1:0] fill_level;
    logic [DATA_W-1:0]  contents;
  } bdr_result_t;

endpackage

// ===== sv/bdr_datapath.sv =====
module bdr_datapath #(
  parameter int BUFFER_WIDTH = bdr_pkg::BUFFER_WIDTH_DEFAULT,
  localparam int CW = $clog2(BUFFER_WIDTH + 1)
) (
  input  logic [2:0]                  func,
  input  logic [bdr_pkg::DATA_W-1:0]  in_bits,
  input  logic [bdr_pkg::COUNT_W-1:0] in_count,
  input  logic [BUFFER_WIDTH-1:0]     buffer_bits,
  input  logic [CW-1:0]               fill_count,
  output logic [BUFFER_WIDTH-1:0]     buffer_bits_next,
  output logic [CW-1:0]               fill_count_next,
  output bdr_pkg::bdr_result_t        result
);
  import bdr_pkg::*;

  localparam int W = BUFFER_WIDTH;
  localparam logic [COUNT_W-1:0] W_IN = COUNT_W'(W);
  localparam logic [CW-1:0]      W_CNT = CW'(W);

  logic [CW-1:0] cnt;
  logic [CW-1:0] keep;
  logic [CW-1:0] spill;
  logic [CW-1:0] pop_cnt;
  logic [CW-1:0] rest;
  logic [CW-1:0] fill_after_spill;
  logic [W-1:0]  fresh;
  logic [W-1:0]  res_bits;
  logic [CW-1:0] res_count;
  logic [W-1:0]  nb;
  logic [CW-1:0] nf;

  // Mask of the low n bits; n equal to the width gives all ones.
  function automatic logic [W-1:0] low_mask(input logic [CW-1:0] n);
    low_mask = ~({W{1'b1}} << n);
  endfunction

  // Saturated count, new bits and the shared spill terms.
  always_comb begin
    cnt              = (in_count > W_IN) ? W_CNT : in_count[CW-1:0];
    fresh            = in_bits[W-1:0] & low_mask(cnt);
    keep             = W_CNT - cnt;
    spill            = (fill_count > keep) ? (fill_count - keep) : '0;
    pop_cnt          = (fill_count > cnt) ? cnt : fill_count;
    rest             = (fill_count > cnt) ? (fill_count - cnt) : '0;
    fill_after_spill = fill_count - spill;
  end

  // One operation on the buffer.
  always_comb begin
    res_bits  = '0;
    res_count = '0;
    nb        = buffer_bits;
    nf        = fill_count;
    unique case (func)
      FUNC_LOAD: begin
        nb = fresh;
        nf = cnt;
      end
      FUNC_PUSH_LOW: begin
        res_count = spill;
        res_bits  = (buffer_bits >> keep) & low_mask(spill);
        nf        = fill_after_spill + cnt;
        nb        = ((buffer_bits << cnt) | fresh) & low_mask(nf);
      end
      FUNC_POP_LOW: begin
        res_count = pop_cnt;
        res_bits  = buffer_bits & low_mask(pop_cnt);
        nf        = fill_count - pop_cnt;
        nb        = (buffer_bits >> cnt) & low_mask(nf);
      end
      FUNC_PUSH_HIGH: begin
        res_count = spill;
        res_bits  = buffer_bits & low_mask(spill);
        nf        = fill_after_spill + cnt;
        nb        = ((buffer_bits >> spill) | (fresh << fill_after_spill)) & low_mask(nf);
      end
      FUNC_POP_HIGH: begin
        res_count = fill_count - rest;
        res_bits  = (buffer_bits >> rest) & low_mask(fill_count - rest);
        nb        = buffer_bits & low_mask(rest);
        nf        = rest;
      end
      default: begin
        // Unused codes leave the state as it is.
        nb = buffer_bits;
        nf = fill_count;
      end
    endcase
  end

  // Next state and the widened result fields.
  always_comb begin
    buffer_bits_next  = nb;
    fill_count_next   = nf;
    result.out_bits   = DATA_W'(res_bits);
    result.out_count  = COUNT_W'(res_count);
    result.fill_level = COUNT_W'(nf);
    result.contents   = DATA_W'(nb);
  end

endmodule

// ===== sv/bit_deque_register_top.sv =====
// Double-ended bit buffer of BUFFER_WIDTH bits with a fill count. Each transfer
// carries one operation (load, push or pop at the low or high end) and produces
// exactly one result: the bits popped or forced out, their count, and the fill
// level and contents after the operation. An item is registered on input, goes
// through the shift and mask logic that also updates the buffer state, and lands
// in the result register, from which its result is offered. One item is
// accepted every cycle while input ready is high; the rate is set by the
// read-modify-write of the buffer register, and input ready drops only while
// both the input register and the result register are held full.
module bit_deque_register_top #(
  parameter int BUFFER_WIDTH = bdr_pkg::BUFFER_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  func,
  input  logic [bdr_pkg::DATA_W-1:0]  in_bits,
  input  logic [bdr_pkg::COUNT_W-1:0] in_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bdr_pkg::DATA_W-1:0]  out_bits,
  output logic [bdr_pkg::COUNT_W-1:0] out_count,
  output logic [bdr_pkg::COUNT_W-1:0] fill_level,
  output logic [bdr_pkg::DATA_W-1:0]  contents
);
  import bdr_pkg::*;

  localparam int CW = $clog2(BUFFER_WIDTH + 1);
  localparam logic [CW-1:0] W_CNT = CW'(BUFFER_WIDTH);

  logic                    s1_valid;
  logic [2:0]              s1_func;
  logic [DATA_W-1:0]       s1_bits;
  logic [COUNT_W-1:0]      s1_count;
  logic [BUFFER_WIDTH-1:0] buffer_bits;
  logic [BUFFER_WIDTH-1:0] buffer_bits_next;
  logic [CW-1:0]           fill_count;
  logic [CW-1:0]           fill_count_next;
  bdr_result_t             result;
  logic                    advance;

  // The input stage moves on whenever the result register is free or drains.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  bdr_datapath #(
    .BUFFER_WIDTH(BUFFER_WIDTH)
  ) u_datapath (
    .func            (s1_func),
    .in_bits         (s1_bits),
    .in_count        (s1_count),
    .buffer_bits     (buffer_bits),
    .fill_count      (fill_count),
    .buffer_bits_next(buffer_bits_next),
    .fill_count_next (fill_count_next),
    .result          (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_func  <= func;
      s1_bits  <= in_bits;
      s1_count <= in_count;
    end
  end

  // Buffer state is updated as the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bits <= '0;
      fill_count  <= '0;
    end else if (s1_valid && advance) begin
      buffer_bits <= buffer_bits_next;
      fill_count  <= fill_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && advance) begin
      out_bits   <= result.out_bits;
      out_count  <= result.out_count;
      fill_level <= result.fill_level;
      contents   <= result.contents;
    end
  end

  // The fill count never exceeds the buffer width.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= W_CNT)
    else $error("fill count above buffer width");

  // Bits above the fill level are always zero.
  a_clean_top: assert property (@(posedge clk) disable iff (rst)
    (buffer_bits & ({BUFFER_WIDTH{1'b1}} << fill_count)) == '0)
    else $error("buffer holds bits above fill level");

  // The reported fill level matches the state just written.
  a_fill_report: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> (fill_level == COUNT_W'(fill_count)))
    else $error("reported fill level differs from buffer state");

  // Input stalls only when both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  // A result never reports more bits than the buffer holds.
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count <= COUNT_W'(BUFFER_WIDTH)))
    else $error("result count above buffer width");

endmodule
